>>> rtl/cfdn_pkg.sv
// shared types, constants and arithmetic helpers for the complex fdn reverb core
// no dependencies
package cfdn_pkg;

	localparam int TAPS        = 4;
	localparam int TAP_BITS    = $clog2(TAPS);
	localparam int LINE_DEPTH  = 4096;
	localparam int PTR_BITS    = $clog2(LINE_DEPTH);
	localparam int MEM_DEPTH   = TAPS * LINE_DEPTH;
	localparam int MEM_ABITS   = $clog2(MEM_DEPTH);
	localparam int SW          = 24;
	localparam int CW          = 16;
	localparam int FRAC        = CW - 1;
	localparam int CFG_W       = 64;
	localparam int MA_W        = 28;
	localparam int MB_W        = 17;
	localparam int P_W         = MA_W + MB_W;
	localparam int ACC_W       = 43;
	localparam int WIDE        = 48;

	// config register indexes
	localparam logic [2:0] REG_ROW_RE = 3'd0;
	localparam logic [2:0] REG_ROW_IM = 3'd1;
	localparam logic [2:0] REG_GAIN   = 3'd2;
	localparam logic [2:0] REG_LPC    = 3'd3;
	localparam logic [2:0] REG_DELAYS = 3'd4;
	localparam logic [2:0] REG_APC    = 3'd5;

	// sequencer step boundaries
	localparam logic [6:0] STEP_RD  = 7'd0;
	localparam logic [6:0] STEP_AP  = 7'd5;
	localparam logic [6:0] STEP_MX  = 7'd13;
	localparam logic [6:0] STEP_GN  = 7'd77;
	localparam logic [6:0] STEP_LP  = 7'd85;
	localparam logic [6:0] STEP_WR  = 7'd101;
	localparam logic [6:0] STEP_OUT = 7'd105;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN, ST_HOLD} state_t;
	typedef enum logic [2:0] {OP_NONE, OP_AP, OP_MX, OP_GN, OP_LP} op_t;

	// round half up by FRAC bits
	function automatic logic signed [WIDE-1:0] rnd_f(input logic signed [WIDE-1:0] v);
		logic signed [WIDE-1:0] t;
		t = v + (WIDE'(1) <<< (FRAC - 1));
		return t >>> FRAC;
	endfunction

	// clamp to the signed sample range
	function automatic logic signed [SW-1:0] sat_s(input logic signed [WIDE-1:0] v);
		logic signed [WIDE-1:0] hi;
		logic signed [WIDE-1:0] lo;
		hi = (WIDE'(1) <<< (SW - 1)) - WIDE'(1);
		lo = -hi - WIDE'(1);
		if (v > hi) return hi[SW-1:0];
		else if (v < lo) return lo[SW-1:0];
		else return v[SW-1:0];
	endfunction

	// packed coefficient entry k
	function automatic logic signed [CW-1:0] coef_at(input logic [CFG_W-1:0] p,
		input logic [TAP_BITS-1:0] k);
		return $signed(p[CW*k +: CW]);
	endfunction

endpackage

>>> rtl/complex_fdn_reverb_core_top.sv
// complex fdn reverb core: sequencer around one shared multiplier and the delay ram
// depends on cfdn_pkg and cfdn_ram
// one word in flight at a time, paced by the single shared multiplier (96 products per word)
// reset: config registers take their defaults, history clears, then a clearing pass zeroes
// all 16384 delay ram words with in_ready low; config writes are taken throughout
module complex_fdn_reverb_core_top
	import cfdn_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [SW-1:0]  in_real,
	input  logic signed [SW-1:0]  in_imag,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [SW-1:0]  out_real,
	output logic signed [SW-1:0]  out_imag,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);
	state_t state_q, state_d;

	logic [CFG_W-1:0] row_re_q, row_im_q, apc_q;
	logic [14:0]      gain_q, lpc_q;
	logic [47:0]      delays_q;

	logic [6:0]          st_q;
	logic [MEM_ABITS-1:0] clr_q;
	logic [PTR_BITS-1:0] wp_q;
	logic signed [SW-1:0] x_re_q, x_im_q;

	logic signed [SW-1:0]    samp_q  [TAPS][2];
	logic signed [SW-1:0]    ap_in_q [TAPS][2];
	logic signed [SW-1:0]    ap_out_q[TAPS][2];
	logic signed [SW-1:0]    lp_q    [TAPS][2];
	logic signed [SW-1:0]    ch_q    [TAPS][2];
	logic signed [ACC_W-1:0] acc_q   [TAPS][2];
	logic signed [P_W-1:0]   lp_acc_q;
	logic signed [SW+1:0]    sum_re_q, sum_im_q;

	logic signed [P_W-1:0] prod_s1;
	op_t                   op_s1;
	logic [5:0]            k_s1;

	op_t                    op_c;
	logic [5:0]             k_c;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;

	logic                  in_acc, out_fire, finish;
	logic                  ram_we;
	logic [MEM_ABITS-1:0]  ram_waddr, ram_raddr;
	logic [2*SW-1:0]       ram_wdata, ram_rdata;
	logic [TAP_BITS-1:0]   rd_line, wr_line;
	logic [PTR_BITS-1:0]   rd_delay;
	logic signed [SW-1:0]  push_re, push_im;
	logic signed [MB_W-1:0] one_minus_a;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign finish   = !out_valid || out_ready;
	assign one_minus_a = $signed(MB_W'(1 << FRAC)) - $signed({2'b00, lpc_q});

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_re_q <= 64'd32767;
			row_im_q <= '0;
			gain_q   <= 15'd29491;
			lpc_q    <= 15'd16073;
			delays_q <= 48'd52097216286899;
			apc_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_RE: row_re_q <= cfg_data;
				REG_ROW_IM: row_im_q <= cfg_data;
				REG_GAIN:   gain_q   <= cfg_data[14:0];
				REG_LPC:    lpc_q    <= cfg_data[14:0];
				REG_DELAYS: delays_q <= cfg_data[47:0];
				REG_APC:    apc_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == MEM_ABITS'(MEM_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (in_acc) state_d = ST_RUN;
			ST_RUN: begin
				if (st_q == STEP_OUT) state_d = finish ? ST_IDLE : ST_HOLD;
			end
			ST_HOLD:  if (finish) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// step counter, clear counter, write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			clr_q <= '0;
			wp_q  <= '0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (in_acc) st_q <= STEP_RD;
			else if (state_q == ST_RUN && st_q != STEP_OUT) st_q <= st_q + 1'b1;
			if (state_q == ST_RUN && st_q == STEP_OUT) wp_q <= wp_q + 1'b1;
		end
	end

	// operation issue decode
	always_comb begin
		logic [TAP_BITS-1:0] i, j, kk;
		logic                c;
		op_c  = OP_NONE;
		k_c   = '0;
		mul_a = '0;
		mul_b = '0;
		i = '0; j = '0; kk = '0; c = 1'b0;
		if (state_q == ST_RUN) begin
			priority if (st_q >= STEP_WR) begin
				op_c = OP_NONE;
			end else if (st_q >= STEP_LP) begin
				op_c = OP_LP;
				k_c  = 6'(st_q - STEP_LP);
				i = k_c[3:2]; c = k_c[1];
				if (!k_c[0]) begin
					mul_a = MA_W'(ch_q[i][c]);
					mul_b = one_minus_a;
				end else begin
					mul_a = MA_W'(lp_q[i][c]);
					mul_b = $signed({2'b00, lpc_q});
				end
			end else if (st_q >= STEP_GN) begin
				op_c = OP_GN;
				k_c  = 6'(st_q - STEP_GN);
				i = k_c[2:1]; c = k_c[0];
				mul_a = MA_W'(rnd_f(WIDE'(acc_q[i][c])));
				mul_b = $signed({2'b00, gain_q});
			end else if (st_q >= STEP_MX) begin
				op_c = OP_MX;
				k_c  = 6'(st_q - STEP_MX);
				i = k_c[5:4]; j = k_c[3:2];
				kk = j - i;
				unique case (k_c[1:0])
					2'd0: begin
						mul_a = MA_W'(ap_out_q[j][0]);
						mul_b = MB_W'(coef_at(row_re_q, kk));
					end
					2'd1: begin
						mul_a = MA_W'(ap_out_q[j][1]);
						mul_b = MB_W'(coef_at(row_im_q, kk));
					end
					2'd2: begin
						mul_a = MA_W'(ap_out_q[j][1]);
						mul_b = MB_W'(coef_at(row_re_q, kk));
					end
					default: begin
						mul_a = MA_W'(ap_out_q[j][0]);
						mul_b = MB_W'(coef_at(row_im_q, kk));
					end
				endcase
			end else if (st_q >= STEP_AP) begin
				op_c = OP_AP;
				k_c  = 6'(st_q - STEP_AP);
				i = k_c[2:1]; c = k_c[0];
				mul_a = MA_W'(ap_out_q[i][c]) - MA_W'(samp_q[i][c]);
				mul_b = MB_W'(coef_at(apc_q, i));
			end else begin
				op_c = OP_NONE;
			end
		end
	end

	// shared multiplier stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
		end else begin
			op_s1 <= op_c;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		k_s1    <= k_c;
	end

	// history state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TAPS; t++) begin
				for (int c = 0; c < 2; c++) begin
					ap_in_q[t][c]  <= '0;
					ap_out_q[t][c] <= '0;
					lp_q[t][c]     <= '0;
				end
			end
		end else begin
			unique case (op_s1)
				OP_AP: begin
					ap_in_q[k_s1[2:1]][k_s1[0]]  <= samp_q[k_s1[2:1]][k_s1[0]];
					ap_out_q[k_s1[2:1]][k_s1[0]] <= sat_s(rnd_f(WIDE'(prod_s1))
						+ WIDE'(ap_in_q[k_s1[2:1]][k_s1[0]]));
				end
				OP_LP: begin
					if (k_s1[0]) begin
						lp_q[k_s1[3:2]][k_s1[1]] <= sat_s(rnd_f(WIDE'(lp_acc_q)
							+ WIDE'(prod_s1)));
					end
				end
				default: ;
			endcase
		end
	end

	// per-word working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_re_q   <= in_real;
			x_im_q   <= in_imag;
			sum_re_q <= '0;
			sum_im_q <= '0;
			for (int t = 0; t < TAPS; t++) begin
				acc_q[t][0] <= '0;
				acc_q[t][1] <= '0;
			end
		end
		// capture delay line reads
		if (state_q == ST_RUN && st_q >= 7'd1 && st_q <= 7'd4) begin
			samp_q[TAP_BITS'(st_q - 7'd1)][0] <= $signed(ram_rdata[SW-1:0]);
			samp_q[TAP_BITS'(st_q - 7'd1)][1] <= $signed(ram_rdata[2*SW-1:SW]);
		end
		unique case (op_s1)
			OP_MX: begin
				unique case (k_s1[1:0])
					2'd0: acc_q[k_s1[5:4]][0] <= acc_q[k_s1[5:4]][0] + ACC_W'(prod_s1);
					2'd1: acc_q[k_s1[5:4]][0] <= acc_q[k_s1[5:4]][0] - ACC_W'(prod_s1);
					default: acc_q[k_s1[5:4]][1] <= acc_q[k_s1[5:4]][1] + ACC_W'(prod_s1);
				endcase
			end
			OP_GN: ch_q[k_s1[2:1]][k_s1[0]] <= sat_s(rnd_f(WIDE'(prod_s1)));
			OP_LP: begin
				if (!k_s1[0]) lp_acc_q <= prod_s1;
				else ch_q[k_s1[3:2]][k_s1[1]] <= sat_s(rnd_f(WIDE'(lp_acc_q)
					+ WIDE'(prod_s1)));
			end
			default: ;
		endcase
		// output sum during the push steps
		if (ram_we && state_q == ST_RUN) begin
			sum_re_q <= sum_re_q + (SW+2)'(ch_q[wr_line][0]);
			sum_im_q <= sum_im_q + (SW+2)'(ch_q[wr_line][1]);
		end
	end

	// delay ram addressing
	assign rd_line   = st_q[TAP_BITS-1:0];
	assign rd_delay  = delays_q[12*rd_line +: PTR_BITS];
	assign ram_raddr = {rd_line, PTR_BITS'(wp_q - rd_delay)};
	assign wr_line   = TAP_BITS'(st_q - STEP_WR);
	assign push_re   = sat_s(WIDE'(x_re_q) + WIDE'(ch_q[wr_line][0]));
	assign push_im   = sat_s(WIDE'(x_im_q) + WIDE'(ch_q[wr_line][1]));

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = (state_q == ST_RUN) && (st_q >= STEP_WR) && (st_q < STEP_OUT);
			ram_waddr = {wr_line, wp_q};
			ram_wdata = {push_im, push_re};
		end
	end

	cfdn_ram #(.W(2*SW), .D(MEM_DEPTH)) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			if ((state_q == ST_RUN && st_q == STEP_OUT && finish)
				|| (state_q == ST_HOLD && finish)) begin
				out_valid <= 1'b1;
			end else if (out_fire) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RUN && st_q == STEP_OUT && finish)
			|| (state_q == ST_HOLD && finish)) begin
			out_real <= sat_s(WIDE'(sum_re_q));
			out_imag <= sat_s(WIDE'(sum_im_q));
		end
	end
endmodule

>>> rtl/cfdn_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module cfdn_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/cfdn_checker.sv
// port-level checks for the complex fdn reverb core, bound to the top level
// depends on cfdn_pkg
module cfdn_checker
	import cfdn_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic signed [SW-1:0] out_real,
	input logic signed [SW-1:0] out_imag
);
	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_real) && $stable(out_imag))
		else $error("output word changed while stalled");

	// in_ready stays low after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##1 !in_ready ##1 !in_ready)
		else $error("input accepted while a word is in work");

	// no result appears right after an accept
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");
endmodule

bind complex_fdn_reverb_core_top cfdn_checker u_cfdn_checker (.*);
